@@ rtl/core/pbrd_pkg.sv @@
package pbrd_pkg;

   localparam int MAX_ROWS    = 4096;
   localparam int ROW_IDX_W   = $clog2(MAX_ROWS + 1);
   localparam int ROW_ADDR_W  = $clog2(MAX_ROWS);
   localparam int LEN_W       = 16;
   localparam int WIDTH_W     = 15;
   localparam int ROWS_W      = 13;
   localparam int LIMIT_W     = WIDTH_W + ROWS_W;
   localparam int TOTAL_W     = 32;
   localparam int CONSUMED_W  = 17;
   localparam int CSR_DATA_W  = 15;

   localparam int FRONT_DEPTH = 4;
   localparam int FRONT_PTR_W = $clog2(FRONT_DEPTH);
   localparam int FRONT_CNT_W = $clog2(FRONT_DEPTH + 1);

   localparam int RSP_DEPTH   = 2;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   localparam logic [0:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [0:0] CSR_IMAGE_ROWS  = 1'b1;

   localparam logic [7:0] HDR_NOP = 8'd128;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_item_type;

   typedef struct packed {
      logic       has_data;
      logic [7:0] value;
      logic [7:0] repeat_count;
      logic       row_done;
      logic       brush_done;
      logic       overflow;
   } rsp_item_type;

endpackage

@@ rtl/core/pbrd_front.sv @@
module pbrd_front
   import pbrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  logic [7:0]    stream_byte,
   output byte_item_type byte_out,
   input  logic          byte_pop
);

   logic [7:0]             data_ff [FRONT_DEPTH];
   logic [FRONT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FRONT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FRONT_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == FRONT_CNT_W'(FRONT_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = byte_pop && (count_ff != '0);
   assign byte_out = '{valid: (count_ff != '0), data: data_ff[rd_ptr_ff]};

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FRONT_CNT_W'(do_push) - FRONT_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= stream_byte;
      end
   end

endmodule

@@ rtl/core/pbrd_decode.sv @@
module pbrd_decode
   import pbrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  byte_item_type         byte_in,
   output logic                  byte_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output rsp_item_type          rsp_item
);

   typedef enum logic [2:0] {
      PH_LEN_HI,
      PH_LEN_LO,
      PH_HEADER,
      PH_RUN_VALUE,
      PH_LITERAL,
      PH_SCAN_RD,
      PH_SCAN_CHK
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [WIDTH_W-1:0]     width_ff, width_in;
   logic [ROWS_W-1:0]      rows_ff, rows_in;
   logic [LIMIT_W-1:0]     limit_ff, limit_in;
   logic [7:0]             len_hi_ff, len_hi_in;
   logic [ROW_IDX_W-1:0]   row_index_ff, row_index_in;
   logic [CONSUMED_W-1:0]  consumed_ff, consumed_in;
   logic [7:0]             lit_left_ff, lit_left_in;
   logic [7:0]             run_len_ff, run_len_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [WIDTH_W-1:0]     cur_len_ff, cur_len_in;
   rsp_item_type           pend_ff, pend_in;

   logic [LEN_W-1:0]       len_mem [MAX_ROWS];
   logic [LEN_W-1:0]       rd_data_ff;
   logic                   mem_we;
   logic [ROW_IDX_W-1:0]   rows_eff;

   // Effective row count: zero acts as one, large values saturate.
   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = ROW_IDX_W'(1);
      end else if (ROW_IDX_W'(rows_ff) > ROW_IDX_W'(MAX_ROWS)) begin
         rows_eff = ROW_IDX_W'(MAX_ROWS);
      end else begin
         rows_eff = ROW_IDX_W'(rows_ff);
      end
   end

   always_comb begin
      rsp_item_type          step;
      logic                  take;
      logic                  bnd;
      logic                  emit;
      logic [CONSUMED_W-1:0] cons;
      logic [TOTAL_W:0]      sum;
      logic [7:0]            add;
      logic [ROW_IDX_W-1:0]  row_next;
      logic [7:0]            b;

      phase_in     = phase_ff;
      width_in     = width_ff;
      rows_in      = rows_ff;
      limit_in     = LIMIT_W'(width_ff) * LIMIT_W'(rows_eff);
      len_hi_in    = len_hi_ff;
      row_index_in = row_index_ff;
      consumed_in  = consumed_ff;
      lit_left_in  = lit_left_ff;
      run_len_in   = run_len_ff;
      total_in     = total_ff;
      cur_len_in   = cur_len_ff;
      pend_in      = pend_ff;
      mem_we       = 1'b0;
      byte_pop     = 1'b0;
      rsp_push     = 1'b0;
      rsp_item     = pend_ff;
      step         = '0;
      bnd          = 1'b0;
      emit         = 1'b0;
      b            = byte_in.data;
      cons         = consumed_ff + 1'b1;
      add          = 8'd0;
      row_next     = row_index_ff + 1'b1;
      take         = byte_in.valid && !rsp_full;

      if (csr_write) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_in = csr_wdata[WIDTH_W-1:0];
         end else begin
            rows_in = csr_wdata[ROWS_W-1:0];
         end
      end

      unique case (phase_ff)
         PH_LEN_HI: begin
            if (take) begin
               byte_pop  = 1'b1;
               len_hi_in = b;
               phase_in  = PH_LEN_LO;
               emit      = 1'b1;
            end
         end
         PH_LEN_LO: begin
            if (take) begin
               byte_pop = 1'b1;
               mem_we   = (row_index_ff < ROW_IDX_W'(MAX_ROWS));
               if (row_next >= rows_eff) begin
                  row_index_in = '0;
                  total_in     = '0;
                  consumed_in  = '0;
                  pend_in      = step;
                  phase_in     = PH_SCAN_RD;
               end else begin
                  row_index_in = row_next;
                  phase_in     = PH_LEN_HI;
                  emit         = 1'b1;
               end
            end
         end
         PH_HEADER: begin
            if (take) begin
               byte_pop      = 1'b1;
               step.overflow = (total_ff > TOTAL_W'(limit_ff));
               consumed_in   = cons;
               if (b == HDR_NOP) begin
                  bnd = 1'b1;
               end else if (b > HDR_NOP) begin
                  run_len_in = 8'(9'd257 - {1'b0, b});
                  phase_in   = PH_RUN_VALUE;
                  emit       = 1'b1;
               end else begin
                  lit_left_in = b + 8'd1;
                  phase_in    = PH_LITERAL;
                  emit        = 1'b1;
               end
            end
         end
         PH_RUN_VALUE: begin
            if (take) begin
               byte_pop          = 1'b1;
               consumed_in       = cons;
               step.has_data     = 1'b1;
               step.value        = b;
               step.repeat_count = run_len_ff;
               add               = run_len_ff;
               bnd               = 1'b1;
            end
         end
         PH_LITERAL: begin
            if (take) begin
               byte_pop          = 1'b1;
               consumed_in       = cons;
               step.has_data     = 1'b1;
               step.value        = b;
               step.repeat_count = 8'd1;
               add               = 8'd1;
               if (lit_left_ff > 8'd1) begin
                  lit_left_in = lit_left_ff - 8'd1;
                  emit        = 1'b1;
               end else begin
                  lit_left_in = 8'd0;
                  bnd         = 1'b1;
               end
            end
         end
         PH_SCAN_RD: begin
            if (row_index_ff >= rows_eff) begin
               if (!rsp_full) begin
                  rsp_push            = 1'b1;
                  rsp_item            = pend_ff;
                  rsp_item.brush_done = 1'b1;
                  row_index_in        = '0;
                  phase_in            = PH_LEN_HI;
               end
            end else begin
               phase_in = PH_SCAN_CHK;
            end
         end
         PH_SCAN_CHK: begin
            if (rd_data_ff == '0 || rd_data_ff[LEN_W-1]) begin
               row_index_in = row_next;
               phase_in     = PH_SCAN_RD;
            end else if (!rsp_full) begin
               rsp_push   = 1'b1;
               rsp_item   = pend_ff;
               cur_len_in = rd_data_ff[WIDTH_W-1:0];
               phase_in   = PH_HEADER;
            end
         end
         default: begin
            phase_in = PH_LEN_HI;
         end
      endcase

      sum = {1'b0, total_ff} + (TOTAL_W + 1)'(add);
      if (add != 8'd0) begin
         total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      end

      // A header boundary closes the row once its length is reached.
      if (bnd) begin
         if (cons >= CONSUMED_W'(cur_len_ff)) begin
            step.row_done = 1'b1;
            row_index_in  = row_next;
            consumed_in   = '0;
            pend_in       = step;
            phase_in      = PH_SCAN_RD;
         end else begin
            phase_in = PH_HEADER;
            emit     = 1'b1;
         end
      end

      if (emit) begin
         rsp_push = 1'b1;
         rsp_item = step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEN_HI;
         width_ff     <= WIDTH_W'(1);
         rows_ff      <= ROWS_W'(1);
         len_hi_ff    <= '0;
         row_index_ff <= '0;
         consumed_ff  <= '0;
         lit_left_ff  <= '0;
         run_len_ff   <= '0;
         total_ff     <= '0;
         cur_len_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         width_ff     <= width_in;
         rows_ff      <= rows_in;
         len_hi_ff    <= len_hi_in;
         row_index_ff <= row_index_in;
         consumed_ff  <= consumed_in;
         lit_left_ff  <= lit_left_in;
         run_len_ff   <= run_len_in;
         total_ff     <= total_in;
         cur_len_ff   <= cur_len_in;
      end
      limit_ff <= limit_in;
      pend_ff  <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         len_mem[row_index_ff[ROW_ADDR_W-1:0]] <= {len_hi_ff, byte_in.data};
      end
      rd_data_ff <= len_mem[row_index_ff[ROW_ADDR_W-1:0]];
   end

endmodule

@@ rtl/core/pbrd_rsp_queue.sv @@
module pbrd_rsp_queue
   import pbrd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type item_in,
   output logic         full,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type item_out
);

   rsp_item_type         data_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == RSP_CNT_W'(RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(do_push) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

@@ rtl/core/packbits_row_decoder_unit.sv @@
// PackBits row decoder. Each accepted byte gives exactly one result. The first
// 2*rows bytes of an image are the big-endian 16-bit compressed length of each
// row; they go into a 4096-entry length table. The bytes that follow are
// PackBits data decoded row by row: a literal header passes the next bytes out
// one at a time with a repeat count of one, a run header gives the next byte
// once with its repeat count, and the no-op header gives an empty result. A row
// closes at a header boundary once its consumed byte count reaches its length;
// rows of length zero or 32768 and above are skipped. In steady state, while the
// result queue has room, the block takes one byte per clock. Each row end and
// the end of the length table start a search of the length table through its
// single registered read port: each row it examines (each skipped empty row
// plus the next non-empty one) passes a read state and a check state, and the
// image ends in the read state when no row is left; no byte is taken during
// the search, and the result of the byte that closed the row is delivered when
// that search finishes. A byte goes through a four-entry input queue and its
// result through a two-entry result queue, so a result reaches the result ports
// only after both its byte and then the result itself have been registered.
// Registers should only be written while no results are pending.
module packbits_row_decoder_unit
   import pbrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // Compressed byte stream.
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_stream_byte,

   // Decoded results.
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_has_data,
   output logic [7:0]            rsp_value,
   output logic [7:0]            rsp_repeat_count,
   output logic                  rsp_row_done,
   output logic                  rsp_brush_done,
   output logic                  rsp_overflow,

   // Register writes: index 0 is the image width, index 1 the row count.
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   byte_item_type byte_item;
   logic          byte_pop;
   logic          queue_full;
   logic          result_push;
   rsp_item_type  result_item;
   rsp_item_type  head_item;

   // The front end buffers incoming bytes so that the decoder can pause for
   // table searches without stalling the upstream transfer.
   pbrd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .stream_byte (req_stream_byte),
      .byte_out    (byte_item),
      .byte_pop    (byte_pop)
   );

   // The decoder holds the length table, the row bookkeeping and the
   // registers; it consumes one byte per step and produces one result.
   pbrd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .byte_in   (byte_item),
      .byte_pop  (byte_pop),
      .rsp_full  (queue_full),
      .rsp_push  (result_push),
      .rsp_item  (result_item)
   );

   // Results wait here until the consumer pops them.
   pbrd_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (result_push),
      .item_in  (result_item),
      .full     (queue_full),
      .empty    (rsp_empty),
      .pop      (rsp_pop),
      .item_out (head_item)
   );

   assign rsp_has_data     = head_item.has_data;
   assign rsp_value        = head_item.value;
   assign rsp_repeat_count = head_item.repeat_count;
   assign rsp_row_done     = head_item.row_done;
   assign rsp_brush_done   = head_item.brush_done;
   assign rsp_overflow     = head_item.overflow;

endmodule

@@ tb/packbits_row_decoder_unit_tb.sv @@
module packbits_row_decoder_unit_tb;
   import pbrd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Where the decoder is in the byte stream. It mirrors the states that the
   // block walks through: the two halves of each row length, then the header
   // of a packet, the value of a run, or the bytes of a literal.
   typedef enum logic [2:0] {
      ST_LEN_HI,
      ST_LEN_LO,
      ST_HEADER,
      ST_RUN_VALUE,
      ST_LITERAL
   } decode_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [7:0]            req_stream_byte = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_has_data;
   logic [7:0]            rsp_value;
   logic [7:0]            rsp_repeat_count;
   logic                  rsp_row_done;
   logic                  rsp_brush_done;
   logic                  rsp_overflow;
   logic                  csr_write = 1'b0;
   logic [0:0]            csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Bytes waiting to be sent, and the decoded results that the accepted bytes
   // must produce, oldest first.
   logic [7:0]   stream_backlog[$];
   rsp_item_type decoded_due[$];
   int           mismatches = 0;
   int           bytes_queued = 0;

   // Our own copy of the register file and of the decoder state.
   int               cfg_width = 1;
   int               cfg_rows = 1;
   decode_phase_type dec_phase = ST_LEN_HI;
   logic [15:0]      length_table[MAX_ROWS];
   logic [7:0]       len_hi = '0;
   int               row_idx = 0;
   int               consumed = 0;
   int               lit_left = 0;
   int               run_len = 0;
   longint           total_out = 0;

   // Scratch storage for building one image before it is queued: the length
   // words go out first, the packet data after them.
   logic [15:0] image_lengths[$];
   logic [7:0]  image_body[$];

   // Sender and receiver pacing.
   bit          steady_mode = 1'b0;
   int          burst_left = 1;
   int          gap_left = 0;
   logic [15:0] pop_pattern = 16'hFFFF;
   int          pop_slot = 0;
   rsp_item_type want;

   packbits_row_decoder_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_stream_byte (req_stream_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_has_data    (rsp_has_data),
      .rsp_value       (rsp_value),
      .rsp_repeat_count(rsp_repeat_count),
      .rsp_row_done    (rsp_row_done),
      .rsp_brush_done  (rsp_brush_done),
      .rsp_overflow    (rsp_overflow),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // A row count of zero behaves as one row, and counts above the table size
   // are clipped to the table size.
   function automatic int active_rows();
      if (cfg_rows == 0) return 1;
      if (cfg_rows > MAX_ROWS) return MAX_ROWS;
      return cfg_rows;
   endfunction

   // Lengths with the top bit set count as empty rows, just like zero.
   function automatic int stored_length(int r);
      if (r >= MAX_ROWS) return 0;
      return (length_table[r] >= 16'h8000) ? 0 : int'(length_table[r]);
   endfunction

   // Move to the next row that holds data. Empty rows are skipped in the same
   // transfer; when no row is left the image is complete and the decoder goes
   // back to reading lengths for the next one.
   function automatic void open_row(inout rsp_item_type r);
      int rows;
      rows = active_rows();
      while (row_idx < rows && stored_length(row_idx) == 0) row_idx++;
      consumed = 0;
      if (row_idx >= rows) begin
         r.brush_done = 1'b1;
         row_idx = 0;
         dec_phase = ST_LEN_HI;
      end else begin
         dec_phase = ST_HEADER;
      end
   endfunction

   // A row can only close between packets. A literal that runs past the row
   // length simply makes the row longer than announced.
   function automatic void header_boundary(inout rsp_item_type r);
      if (consumed >= stored_length(row_idx)) begin
         r.row_done = 1'b1;
         row_idx++;
         open_row(r);
      end else begin
         dec_phase = ST_HEADER;
      end
   endfunction

   // Advance the decoder by one stream byte and return the result it causes.
   function automatic rsp_item_type decode_byte(logic [7:0] b);
      rsp_item_type r;
      r = '0;
      case (dec_phase)
         ST_LEN_HI: begin
            len_hi = b;
            dec_phase = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            if (row_idx < MAX_ROWS) length_table[row_idx] = {len_hi, b};
            row_idx++;
            if (row_idx >= active_rows()) begin
               row_idx = 0;
               total_out = 0;
               open_row(r);
            end else begin
               dec_phase = ST_LEN_HI;
            end
         end
         ST_HEADER: begin
            // The size check looks at what was decoded before this header.
            if (total_out > longint'(cfg_width) * active_rows()) r.overflow = 1'b1;
            consumed++;
            if (b == HDR_NOP) begin
               header_boundary(r);
            end else if (b > HDR_NOP) begin
               run_len = 257 - int'(b);
               dec_phase = ST_RUN_VALUE;
            end else begin
               lit_left = int'(b) + 1;
               dec_phase = ST_LITERAL;
            end
         end
         ST_RUN_VALUE: begin
            consumed++;
            r.has_data = 1'b1;
            r.value = b;
            r.repeat_count = run_len[7:0];
            total_out = total_out + run_len;
            if (total_out > 64'hFFFF_FFFF) total_out = 64'hFFFF_FFFF;
            header_boundary(r);
         end
         ST_LITERAL: begin
            consumed++;
            r.has_data = 1'b1;
            r.value = b;
            r.repeat_count = 8'd1;
            total_out = total_out + 1;
            if (total_out > 64'hFFFF_FFFF) total_out = 64'hFFFF_FFFF;
            if (lit_left > 0) lit_left--;
            if (lit_left == 0) header_boundary(r);
         end
         default: begin
            dec_phase = ST_LEN_HI;
         end
      endcase
      return r;
   endfunction

   function automatic void note_result(rsp_item_type r);
      decoded_due.insert(decoded_due.size(), r);
   endfunction

   // Sender. Bytes leave the backlog in bursts of random length separated by
   // random gaps; in steady mode the gaps vanish. A byte that meets a full
   // input queue is held until it is taken. Each accepted byte is run through
   // the decoder copy right away, so the expectations stay in stream order.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            note_result(decode_byte(stream_backlog.pop_front()));
         end
         if (!(req_push && req_full)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (stream_backlog.size() > 0) begin
               req_push <= 1'b1;
               req_stream_byte <= stream_backlog[0];
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = steady_mode ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   function automatic void compare_field(string name, logic [7:0] exp_val,
                                         logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   // Receiver. Pop follows a 16-bit rotating pattern that is redrawn whenever the
   // slot counter wraps; a quarter of the patterns pop on every cycle, which gives long
   // stretches with no back-pressure at all.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (decoded_due.size() == 0) begin
               $display("%0t ns: result transfer with nothing expected, value %0d count %0d",
                        $time, rsp_value, rsp_repeat_count);
               mismatches++;
            end else begin
               want = decoded_due.pop_front();
               compare_field("has_data", want.has_data, rsp_has_data);
               compare_field("value", want.value, rsp_value);
               compare_field("repeat_count", want.repeat_count, rsp_repeat_count);
               compare_field("row_done", want.row_done, rsp_row_done);
               compare_field("brush_done", want.brush_done, rsp_brush_done);
               compare_field("overflow", want.overflow, rsp_overflow);
            end
         end
         if (pop_slot == 0) begin
            pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
         end
         pop_slot = (pop_slot + 1) % 80;
         rsp_pop <= pop_pattern[0];
         pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      end
   end

   function automatic void queue_byte(logic [7:0] b);
      stream_backlog.insert(stream_backlog.size(), b);
      bytes_queued++;
   endfunction

   // Queue a short fixed sequence, first byte in the top bits.
   function automatic void queue_seq(int n, logic [255:0] seq);
      for (int i = n - 1; i >= 0; i--) queue_byte(seq[8*i +: 8]);
   endfunction

   // Registers are only touched while the block is idle. The write lands at the
   // edge that samples the strobe, and our copy follows at that same point.
   task automatic write_reg(input logic [0:0] idx, input int val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) cfg_width = val & 'h7FFF;
      else cfg_rows = val & 'h1FFF;
      @(negedge clock);
   endtask

   // Idle means every byte was taken and every result has come back. Each byte
   // yields exactly one result, so nothing can still be in flight after that.
   task automatic wait_idle();
      while (stream_backlog.size() != 0 || req_push || decoded_due.size() != 0)
         @(negedge clock);
   endtask

   // Feed no-op headers until the decoder stands at the start of a new image.
   // They end rows in the data part, close open literals and runs, and read as
   // empty row lengths in the length part.
   task automatic settle();
      wait_idle();
      while (!(dec_phase == ST_LEN_HI && row_idx == 0)) begin
         queue_byte(HDR_NOP);
         wait_idle();
      end
   endtask

   function automatic void add_body_byte(logic [7:0] b);
      image_body.insert(image_body.size(), b);
   endfunction

   // One PackBits packet into the image body; n returns its size in bytes.
   // Literals are mostly short, with the occasional long one up to 128 bytes.
   task automatic add_packet(output int n);
      int kind;
      int cnt;
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
         cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
         add_body_byte(8'(cnt));
         for (int i = 0; i <= cnt; i++) add_body_byte(8'($urandom));
         n = cnt + 2;
      end else if (kind < 9) begin
         add_body_byte(8'($urandom_range(129, 255)));
         add_body_byte(8'($urandom));
         n = 2;
      end else begin
         add_body_byte(HDR_NOP);
         n = 1;
      end
   endtask

   // Build and queue a well-formed image of the given row count. A row length
   // may fall anywhere inside the last packet of its row, which still closes the
   // row at that packet.
   task automatic queue_image(input int rows, input int max_target, input int empty_pct);
      int          row_bytes;
      int          last;
      int          target;
      logic [15:0] len;
      for (int r = 0; r < rows; r++) begin
         if ($urandom_range(0, 99) < empty_pct) begin
            len = $urandom_range(0, 1) ? 16'h0000 : (16'h8000 | 16'($urandom));
         end else begin
            row_bytes = 0;
            target = $urandom_range(1, max_target);
            while (row_bytes < target) begin
               add_packet(last);
               row_bytes += last;
            end
            len = 16'(row_bytes - $urandom_range(0, last - 1));
         end
         image_lengths.insert(image_lengths.size(), len);
      end
      foreach (image_lengths[i]) begin
         queue_byte(image_lengths[i][15:8]);
         queue_byte(image_lengths[i][7:0]);
      end
      foreach (image_body[i]) queue_byte(image_body[i]);
      image_lengths.delete();
      image_body.delete();
   endtask

   initial begin
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Three rows at the reset width of one pixel. Row 0 has a literal of two
      // bytes (0x00 and 0xFF), the longest run of 128 and a no-op header. Row 1 has
      // length 0x8000 and is skipped. Row 2 has the shortest run and then a
      // literal that overshoots its length. The size check trips from the
      // third header of the image on.
      write_reg(CSR_IMAGE_ROWS, 3);
      queue_seq(17, {48'h00_06_80_00_00_03, 48'h01_00_FF_81_A5_80, 40'hFF_5A_01_33_44});
      settle();

      // Every row empty: the image ends on its last length byte.
      write_reg(CSR_IMAGE_ROWS, 2);
      queue_seq(4, 32'h00_00_FF_FF);
      settle();

      // Row count lowered in the middle of an image: row 1 is open when the
      // count drops to one, so its end is also the end of the image.
      queue_seq(6, 48'h00_01_00_02_80_80);
      wait_idle();
      write_reg(CSR_IMAGE_ROWS, 1);
      queue_byte(HDR_NOP);
      settle();

      // Random phases: each picks a setting, sends a few images and sometimes
      // a few noise bytes with the top bit set, which read as empty row
      // lengths, then brings the decoder back to an image start.
      while (bytes_queued < 700) begin
         pick = $urandom_range(0, 5);
         case (pick)
            0: write_reg(CSR_IMAGE_WIDTH, 0);
            1: write_reg(CSR_IMAGE_WIDTH, 1);
            2: write_reg(CSR_IMAGE_WIDTH, 16384);
            3: write_reg(CSR_IMAGE_WIDTH, 32767);
            4: write_reg(CSR_IMAGE_WIDTH, $urandom_range(1, 16384));
            default: write_reg(CSR_IMAGE_WIDTH, $urandom_range(1, 8));
         endcase
         pick = $urandom_range(0, 4);
         case (pick)
            0: write_reg(CSR_IMAGE_ROWS, 0);
            1: write_reg(CSR_IMAGE_ROWS, 1);
            default: write_reg(CSR_IMAGE_ROWS, $urandom_range(2, 12));
         endcase
         steady_mode = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) queue_image(active_rows(), 40, 15);
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 30)) queue_byte(8'($urandom) | 8'h80);
         end
         settle();
      end

      // Give a stray extra result the time to show up.
      repeat (40) @(posedge clock);
      if (mismatches == 0 && decoded_due.size() == 0) begin
         $display("packbits_row_decoder_unit test passed");
      end else begin
         $display("packbits_row_decoder_unit test failed");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run of the stimulus above.
   initial begin
      #15_000_000;
      $display("packbits_row_decoder_unit test failed");
      $finish;
   end

endmodule
